// ===== src/periodic_task_slot_scheduler_core_assert.svh =====
// Assertion macros for the periodic task slot scheduler.
// Included by the checker module; needs nothing else.
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define PTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pts_pkg.sv =====
// Shared types and codes for the periodic task slot scheduler.
// Used by the controller, the datapath, the top level and the checker.
package pts_pkg;

    // operation codes of an input item
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_ADD  = 2'd1;
    localparam logic [1:0] FUNC_DEL  = 2'd2;
    localparam logic [1:0] FUNC_RSVD = 2'd3;

    // kinds of a result item
    localparam logic [1:0] KIND_DUE = 2'd0;
    localparam logic [1:0] KIND_ADD = 2'd1;
    localparam logic [1:0] KIND_DEL = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        task_id;
        logic [15:0]        period;
        logic [15:0]        delay;
        logic signed [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] due_id;
        logic [31:0] lateness;
        logic        ok;
        logic        last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// ===== src/periodic_task_slot_scheduler_core.sv =====
// Top level of the periodic task slot scheduler.
// Instantiates pts_ctrl and pts_dpath; types from pts_pkg.
//
//  port group   direction  payload     handshake
//  input item   in         i_item      i_valid / o_stall
//  result item  out        o_res       o_valid / i_stall
//
// Every accepted add, delete or fresh tick walks all SLOTS slots, one slot
// per cycle through the slot memory's registered read port while the result
// side does not stall; the input stalls until the walk and its finish are done.
// A repeated tick or an unused operation code finishes in its accept cycle.
// Reset clears the slot flags, the last tick and all control state.
// A stalled result holds the walk at each further due slot and at the finish.
module periodic_task_slot_scheduler_core #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pts_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output pts_pkg::t_out_item o_res
);

    pts_pkg::t_cmd cmd;
    pts_pkg::t_sts sts;

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (sts),
        .o_in_stall (o_stall),
        .o_cmd      (cmd)
    );

    pts_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_out       (o_res)
    );

endmodule

// ===== src/pts_ctrl.sv =====
// Controller of the slot scheduler: idle, slot walk, finish.
// Uses pts_pkg command and status types.
module pts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pts_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output pts_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_sts.skip) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/pts_dpath.sv =====
// Datapath of the slot scheduler: slot memory, walk pointer, compare stage,
// pending due result and output register. Uses pts_pkg.
module pts_dpath #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pts_pkg::t_in_item  i_item,
    input  pts_pkg::t_cmd      i_cmd,
    output pts_pkg::t_sts      o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output pts_pkg::t_out_item o_out
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // slot memory and per-slot written flags
    logic [31:0] r_mem_task [SLOTS];
    logic [15:0] r_mem_per  [SLOTS];
    logic [31:0] r_mem_dl   [SLOTS];
    logic [SLOTS-1:0] r_vld;

    pts_pkg::t_in_item  r_in;
    logic [31:0]        r_last_tick;
    logic [CW-1:0]      r_ptr;
    logic               r_ev_v;
    logic [IW-1:0]      r_ev_idx;
    logic               r_rd_vld;
    logic [31:0]        r_rd_task;
    logic [15:0]        r_rd_per;
    logic [31:0]        r_rd_dl;
    logic               r_have;
    logic [IW-1:0]      r_sel;
    logic               r_pend_v;
    logic [IW-1:0]      r_pend_slot;
    logic [31:0]        r_pend_id;
    logic [31:0]        r_pend_late;
    logic               r_out_v;
    pts_pkg::t_out_item r_out;
    pts_pkg::t_out_item n_out;

    logic [31:0] eff_task;
    logic [31:0] now_u;
    logic        out_free;
    logic        is_match;
    logic        is_due;
    logic        need_push;
    logic        adv;
    logic        ptr_in;
    logic        eval;
    logic        fin_go;
    logic        out_push;
    logic        tick_wr;
    logic        add_wr;
    logic        del_wr;

    // compare stage
    assign now_u     = $unsigned(r_in.now);
    assign eff_task  = r_rd_vld ? r_rd_task : 32'd0;
    assign is_match  = (eff_task == r_in.task_id);
    assign is_due    = (r_in.func == pts_pkg::FUNC_TICK) && (eff_task != 32'd0)
                       && ($signed(r_rd_dl) <= r_in.now);
    assign out_free  = !r_out_v || !i_out_stall;
    assign need_push = r_ev_v && is_due && r_pend_v;
    assign adv       = i_cmd.scan && (!need_push || out_free);
    assign ptr_in    = (r_ptr < CW'(SLOTS));
    assign eval      = adv && r_ev_v;
    assign tick_wr   = eval && is_due;
    assign fin_go    = i_cmd.fin && out_free;
    assign add_wr    = fin_go && (r_in.func == pts_pkg::FUNC_ADD) && r_have;
    assign del_wr    = fin_go && (r_in.func == pts_pkg::FUNC_DEL) && r_have;

    // status
    assign o_sts.skip      = (i_item.func == pts_pkg::FUNC_RSVD)
                             || ((i_item.func == pts_pkg::FUNC_TICK)
                                 && ($unsigned(i_item.now) == r_last_tick));
    assign o_sts.scan_done = (r_ptr == CW'(SLOTS)) && !r_ev_v;
    assign o_sts.out_free  = out_free;

    // memory writes
    always_ff @(posedge i_clk) begin
        if (add_wr || del_wr) begin
            r_mem_task[r_sel] <= add_wr ? r_in.task_id : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (add_wr) begin
            r_mem_per[r_sel] <= r_in.period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_wr) begin
            r_mem_dl[r_ev_idx] <= now_u + {16'd0, r_rd_per};
        end else if (add_wr) begin
            r_mem_dl[r_sel] <= now_u + {16'd0, r_in.delay};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (add_wr || del_wr) begin
            r_vld[r_sel] <= 1'b1;
        end
    end

    // registered slot read, one slot per advance
    always_ff @(posedge i_clk) begin
        if (adv && ptr_in) begin
            r_rd_task <= r_mem_task[r_ptr[IW-1:0]];
            r_rd_per  <= r_mem_per[r_ptr[IW-1:0]];
            r_rd_dl   <= r_mem_dl[r_ptr[IW-1:0]];
            r_rd_vld  <= r_vld[r_ptr[IW-1:0]];
        end
    end

    // input capture and last tick
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tick <= 32'd0;
        end else if (i_cmd.accept && (i_item.func == pts_pkg::FUNC_TICK)) begin
            r_last_tick <= $unsigned(i_item.now);
        end
    end

    // walk pointer and compare stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_ev_v <= 1'b0;
        end else if (i_cmd.accept) begin
            r_ptr  <= '0;
            r_ev_v <= 1'b0;
        end else if (adv) begin
            r_ev_v <= ptr_in;
            if (ptr_in) begin
                r_ptr <= r_ptr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && ptr_in) begin
            r_ev_idx <= r_ptr[IW-1:0];
        end
    end

    // add: last match, else first free; delete: first match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.accept) begin
            r_have <= 1'b0;
        end else if (eval) begin
            if (r_in.func == pts_pkg::FUNC_ADD) begin
                if (is_match || ((eff_task == 32'd0) && !r_have)) begin
                    r_have <= 1'b1;
                    r_sel  <= r_ev_idx;
                end
            end else if (r_in.func == pts_pkg::FUNC_DEL) begin
                if (is_match && !r_have) begin
                    r_have <= 1'b1;
                    r_sel  <= r_ev_idx;
                end
            end
        end
    end

    // pending due result, held until the next one or the walk end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.accept || fin_go) begin
            r_pend_v <= 1'b0;
        end else if (tick_wr) begin
            r_pend_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_wr) begin
            r_pend_slot <= r_ev_idx;
            r_pend_id   <= eff_task;
            r_pend_late <= now_u - r_rd_dl;
        end
    end

    // result selection
    always_comb begin
        n_out          = '0;
        n_out.slot     = 4'(r_pend_slot);
        n_out.due_id   = r_pend_id;
        n_out.lateness = r_pend_late;
        n_out.ok       = 1'b1;
        n_out.kind     = pts_pkg::KIND_DUE;
        out_push       = 1'b0;
        if (i_cmd.fin) begin
            n_out.last = 1'b1;
            priority if (r_in.func == pts_pkg::FUNC_ADD
                         || r_in.func == pts_pkg::FUNC_DEL) begin
                out_push       = fin_go;
                n_out.kind     = (r_in.func == pts_pkg::FUNC_ADD) ?
                                 pts_pkg::KIND_ADD : pts_pkg::KIND_DEL;
                n_out.lateness = 32'd0;
                n_out.ok       = r_have;
                n_out.slot     = r_have ? 4'(r_sel) : 4'd0;
                n_out.due_id   = r_have ? r_in.task_id : 32'd0;
            end else begin
                out_push = fin_go && r_pend_v;
            end
        end else begin
            out_push = adv && need_push;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_push) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

// ===== src/pts_checker.sv =====
// Port-level checks for the periodic task slot scheduler, bound to the top.
// Uses pts_pkg and the macros of periodic_task_slot_scheduler_core_assert.svh.
`include "periodic_task_slot_scheduler_core_assert.svh"

module pts_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_stall,
    input pts_pkg::t_in_item  i_in,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input pts_pkg::t_out_item i_out
);

    // a stalled result holds
    `PTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out), "stalled result changed")

    // add and delete give one reply, which is always the last result
    `PTS_ASSERT_IMPLY(a_reply_last, i_clk, i_rst_n, i_out_valid && (i_out.kind != pts_pkg::KIND_DUE), i_out.last, "reply not marked last")

    // a failed reply names no slot and no task
    `PTS_ASSERT_IMPLY(a_fail_clean, i_clk, i_rst_n, i_out_valid && !i_out.ok, (i_out.slot == 4'd0) && (i_out.due_id == 32'd0) && (i_out.kind != pts_pkg::KIND_DUE), "failed reply carries data")

    // a due task always has a nonzero id and ok set
    `PTS_ASSERT_IMPLY(a_due_ok, i_clk, i_rst_n, i_out_valid && (i_out.kind == pts_pkg::KIND_DUE), i_out.ok && (i_out.due_id != 32'd0), "bad due result")

    // add and delete always start a slot walk
    `PTS_ASSERT_NEXT(a_walk_busy, i_clk, i_rst_n, i_in_valid && !i_in_stall && ((i_in.func == pts_pkg::FUNC_ADD) || (i_in.func == pts_pkg::FUNC_DEL)), i_in_stall, "no walk after add or delete")

endmodule

bind periodic_task_slot_scheduler_core pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_in        (i_item),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out       (o_res)
);
